// ===== design/sps_pkg.sv =====
package sps_pkg;

  localparam int PROG_DEPTH = 32;
  localparam int PTR_W      = $clog2(PROG_DEPTH);

  typedef logic [PTR_W-1:0] ptr_t;
  typedef logic [7:0]       byte_t;
  typedef logic [15:0]      tpu_t;
  typedef logic [23:0]      wait_t;
  typedef logic [3:0]       coil_t;

  localparam coil_t COIL_FIRST = 4'h1;
  localparam coil_t COIL_MASK  = 4'hF;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_START = 2'd2
  } cmd_e;

  typedef enum logic [7:0] {
    OP_RESTART = 8'd0,
    OP_CW      = 8'd1,
    OP_CCW     = 8'd2,
    OP_DWELL   = 8'd3
  } op_e;

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_FETCH = 2'd1,
    MODE_STEP  = 2'd2,
    MODE_HALT  = 2'd3
  } mode_e;

  typedef struct packed {
    coil_t      coil_drive;
    logic       running;
    logic       fault;
    logic [1:0] phase_index;
  } result_t;

  // pointer plus a small offset, wrapped to the store depth
  function automatic ptr_t ptr_add(ptr_t ptr, logic [1:0] off);
    logic [PTR_W:0] sum;
    sum = {1'b0, ptr} + (PTR_W + 1)'(off);
    if (sum >= (PTR_W + 1)'(PROG_DEPTH)) begin
      sum = sum - (PTR_W + 1)'(PROG_DEPTH);
    end
    return sum[PTR_W-1:0];
  endfunction

  function automatic wait_t delay_ticks(byte_t units, tpu_t tpu);
    wait_t prod;
    prod = wait_t'(units) * wait_t'(tpu);
    return prod;
  endfunction

endpackage

// ===== design/sps_if.sv =====
interface sps_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [4:0] load_addr;
  logic [7:0] load_data;

  modport source (output valid, output cmd, output load_addr, output load_data, input ready);
  modport sink (input valid, input cmd, input load_addr, input load_data, output ready);
endinterface

interface sps_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] coil_drive;
  logic       running;
  logic       fault;
  logic [1:0] phase_index;

  modport source (output valid, output coil_drive, output running, output fault,
                  output phase_index, input ready);
  modport sink (input valid, input coil_drive, input running, input fault,
                input phase_index, output ready);
endinterface

interface sps_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== design/sps_prog_mem.sv =====
module sps_prog_mem (
  input  logic          clk_i,
  input  logic          we_i,
  input  sps_pkg::ptr_t waddr_i,
  input  sps_pkg::byte_t wdata_i,
  input  sps_pkg::ptr_t raddr_i,
  output sps_pkg::byte_t rdata_o
);

  sps_pkg::byte_t mem_q [sps_pkg::PROG_DEPTH];
  sps_pkg::byte_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // write-first: a byte written this cycle shows up at once
  always_ff @(posedge clk_i) begin
    if (we_i && (waddr_i == raddr_i)) begin
      rdata_q <= wdata_i;
    end else begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/stepper_program_sequencer_unit.sv =====
// Wave-drive stepper sequencer. Takes one input item (tick, program write or start) every
// clock cycle and returns one result per item through a single output register, so the
// input keeps flowing while a result waits, as long as the sink takes one per cycle. The
// state update for an item is done in the cycle it transfers: three copies of the 32-byte
// program store each keep a registered read of the byte at pointer, pointer+1 and pointer+2,
// refreshed every cycle for the next pointer, so a fetch or a step never waits on a read.
// The delay load is an 8x16 multiply in the same cycle. The store needs no clearing after
// reset; only written bytes are meaningful. ticks_per_unit is written through the cfg
// channel, which is always ready, and should be written only while no item is in flight.
module stepper_program_sequencer_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  sps_in_if.sink     in_i,
  sps_out_if.source  out_o,
  sps_cfg_if.sink    cfg_i
);

  sps_pkg::ptr_t    ptr_q, ptr_d;
  logic [1:0]       phase_q, phase_d;
  sps_pkg::byte_t   steps_q, steps_d;
  sps_pkg::wait_t   wait_q, wait_d;
  sps_pkg::mode_e   mode_q, mode_d;
  sps_pkg::coil_t   coil_q, coil_d;
  logic             fault_q, fault_d;
  sps_pkg::tpu_t    tpu_q;
  sps_pkg::result_t res_q;
  logic             out_valid_q;

  logic             accept;
  logic             mem_we;
  sps_pkg::ptr_t    mem_waddr;
  sps_pkg::byte_t   rd0, rd1, rd2;
  sps_pkg::cmd_e    cmd;

  assign cmd       = sps_pkg::cmd_e'(in_i.cmd);
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept    = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;

  assign mem_waddr = sps_pkg::ptr_t'(in_i.load_addr);
  assign mem_we    = accept && (cmd == sps_pkg::CMD_WRITE) &&
                     (32'(in_i.load_addr) < sps_pkg::PROG_DEPTH);

  sps_prog_mem u_mem0 (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (in_i.load_data),
    .raddr_i (ptr_d),
    .rdata_o (rd0)
  );

  sps_prog_mem u_mem1 (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (in_i.load_data),
    .raddr_i (sps_pkg::ptr_add(ptr_d, 2'd1)),
    .rdata_o (rd1)
  );

  sps_prog_mem u_mem2 (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (in_i.load_data),
    .raddr_i (sps_pkg::ptr_add(ptr_d, 2'd2)),
    .rdata_o (rd2)
  );

  always_comb begin
    sps_pkg::byte_t steps_dec;
    logic [1:0]     phase_new;
    ptr_d     = ptr_q;
    phase_d   = phase_q;
    steps_d   = steps_q;
    wait_d    = wait_q;
    mode_d    = mode_q;
    coil_d    = coil_q;
    fault_d   = fault_q;
    steps_dec = steps_q - 8'd1;
    phase_new = (rd0 == sps_pkg::OP_CCW) ? (phase_q - 2'd1) : (phase_q + 2'd1);
    if (accept) begin
      case (cmd)
        sps_pkg::CMD_START: begin
          ptr_d   = '0;
          wait_d  = '0;
          steps_d = '0;
          fault_d = 1'b0;
          mode_d  = sps_pkg::MODE_FETCH;
        end
        sps_pkg::CMD_TICK: begin
          if ((mode_q == sps_pkg::MODE_FETCH) || (mode_q == sps_pkg::MODE_STEP)) begin
            if (wait_q != '0) begin
              wait_d = wait_q - sps_pkg::wait_t'(1);
            end else if (mode_q == sps_pkg::MODE_FETCH) begin
              case (rd0)
                sps_pkg::OP_RESTART: ptr_d = '0;
                sps_pkg::OP_CW, sps_pkg::OP_CCW: begin
                  if (rd1 == '0) begin
                    ptr_d = sps_pkg::ptr_add(ptr_q, 2'd3);
                  end else begin
                    steps_d = rd1;
                    mode_d  = sps_pkg::MODE_STEP;
                  end
                end
                sps_pkg::OP_DWELL: begin
                  wait_d = sps_pkg::delay_ticks(rd1, tpu_q);
                  ptr_d  = sps_pkg::ptr_add(ptr_q, 2'd2);
                end
                default: begin
                  fault_d = 1'b1;
                  mode_d  = sps_pkg::MODE_HALT;
                end
              endcase
            end else begin
              // one step; pointer stays on the move opcode until the last one
              phase_d = phase_new;
              coil_d  = (sps_pkg::COIL_FIRST << phase_new) & sps_pkg::COIL_MASK;
              wait_d  = sps_pkg::delay_ticks(rd2, tpu_q);
              steps_d = steps_dec;
              if (steps_dec == '0) begin
                ptr_d  = sps_pkg::ptr_add(ptr_q, 2'd3);
                mode_d = sps_pkg::MODE_FETCH;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q   <= '0;
      phase_q <= '0;
      steps_q <= '0;
      wait_q  <= '0;
      mode_q  <= sps_pkg::MODE_IDLE;
      coil_q  <= '0;
      fault_q <= 1'b0;
    end else begin
      ptr_q   <= ptr_d;
      phase_q <= phase_d;
      steps_q <= steps_d;
      wait_q  <= wait_d;
      mode_q  <= mode_d;
      coil_q  <= coil_d;
      fault_q <= fault_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tpu_q <= 16'd1;
    end else if (cfg_i.valid && cfg_i.ready) begin
      tpu_q <= cfg_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q.coil_drive  <= coil_d;
      res_q.running     <= (mode_d == sps_pkg::MODE_FETCH) || (mode_d == sps_pkg::MODE_STEP);
      res_q.fault       <= fault_d;
      res_q.phase_index <= phase_d;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.coil_drive  = res_q.coil_drive;
  assign out_o.running     = res_q.running;
  assign out_o.fault       = res_q.fault;
  assign out_o.phase_index = res_q.phase_index;

  a_fault_halted : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fault_q |-> (mode_q == sps_pkg::MODE_HALT))
    else $error("fault flag set outside halted mode");

  a_step_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == sps_pkg::MODE_STEP) |-> (steps_q != '0))
    else $error("stepping with no steps left");

  a_coil_onehot : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(coil_q))
    else $error("coil pattern not one-hot");

  a_result_follows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_q)
    else $error("transfer in gave no result");

  a_idle_tick : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (cmd == sps_pkg::CMD_TICK) &&
     ((mode_q == sps_pkg::MODE_IDLE) || (mode_q == sps_pkg::MODE_HALT)))
    |=> ($stable(ptr_q) && $stable(phase_q) && $stable(coil_q)))
    else $error("tick changed state while not running");

endmodule
